/* rtl/tccs_pkg.sv */
package tccs_pkg;

	localparam int POS_W = 11;
	localparam int CH_W  = 8;

	localparam logic [CH_W-1:0] CH_NUL     = 8'd0;
	localparam logic [CH_W-1:0] CH_NEWLINE = 8'd10;
	localparam logic [CH_W-1:0] CH_TAB     = 8'd9;

	localparam logic [2:0] CL_NUL   = 3'd0;
	localparam logic [2:0] CL_CLEAR = 3'd1;
	localparam logic [2:0] CL_NL    = 3'd2;
	localparam logic [2:0] CL_TAB   = 3'd3;
	localparam logic [2:0] CL_PRINT = 3'd4;

	typedef struct packed {
		logic [2:0]      cls;
		logic [CH_W-1:0] ch;
	} req_t;

endpackage

/* rtl/text_console_cursor_scroll.sv */
// The result is registered; it is set when the back end takes its request.
// Throughput: one request every cycle when no scroll or clear is needed and
// out_ready stays high. Scroll or clear: a sweep over every screen RAM cell
// runs before the result is valid.
// Reset: cursor homes; a clearing pass zeroes the screen RAM, and no request
// is taken until that pass is done.
module text_console_cursor_scroll #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       cmd,
	input  logic [7:0]                 char_in,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [tccs_pkg::POS_W-1:0] cursor_cell,
	output logic                       cell_written,
	output logic [tccs_pkg::POS_W-1:0] cell_index,
	output logic [tccs_pkg::CH_W-1:0]  cell_char,
	output logic                       scrolled
);
	import tccs_pkg::*;

	logic head_valid;
	req_t head;
	logic pop;
	logic init_busy;

	tccs_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.cmd        (cmd),
		.char_in    (char_in),
		.hold       (init_busy),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	tccs_back #(
		.COLUMNS  (COLUMNS),
		.ROWS     (ROWS),
		.TAB_STOP (TAB_STOP)
	) u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head_valid   (head_valid),
		.head         (head),
		.pop          (pop),
		.init_busy    (init_busy),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.cursor_cell  (cursor_cell),
		.cell_written (cell_written),
		.cell_index   (cell_index),
		.cell_char    (cell_char),
		.scrolled     (scrolled)
	);

endmodule

/* rtl/tccs_ram.sv */
module tccs_ram #(
	parameter int W = 8,
	parameter int D = 2000
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

/* rtl/tccs_front.sv */
module tccs_front (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic                   cmd,
	input  logic [7:0]             char_in,
	input  logic                   hold,
	output logic                   head_valid,
	output tccs_pkg::req_t         head,
	input  logic                   pop
);
	import tccs_pkg::*;

	req_t       q_q [2];
	logic       wp_q;
	logic       rp_q;
	logic [1:0] cnt_q;
	req_t       req;
	logic       push;

	always_comb begin
		req.ch = char_in;
		if (cmd) begin
			req.cls = CL_CLEAR;
		end else begin
			case (char_in)
				CH_NUL:     req.cls = CL_NUL;
				CH_NEWLINE: req.cls = CL_NL;
				CH_TAB:     req.cls = CL_TAB;
				default:    req.cls = CL_PRINT;
			endcase
		end
	end

	assign in_ready   = (cnt_q != 2'd2) && !hold;
	assign push       = in_valid && in_ready;
	assign head_valid = (cnt_q != 2'd0);
	assign head       = q_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) begin
			q_q[wp_q] <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wp_q <= ~wp_q;
			end
			if (pop) begin
				rp_q <= ~rp_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(pop);
		end
	end

`ifndef SYNTHESIS
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head_valid) else $error("pop from empty queue");
`endif

endmodule

/* rtl/tccs_back.sv */
module tccs_back #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          head_valid,
	input  tccs_pkg::req_t                head,
	output logic                          pop,
	output logic                          init_busy,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [tccs_pkg::POS_W-1:0]    cursor_cell,
	output logic                          cell_written,
	output logic [tccs_pkg::POS_W-1:0]    cell_index,
	output logic [tccs_pkg::CH_W-1:0]     cell_char,
	output logic                          scrolled
);
	import tccs_pkg::*;

	localparam int CELLS = COLUMNS * ROWS;
	localparam int CW    = $clog2(CELLS + 1);
	localparam int AW    = $clog2(CELLS);
	localparam int CLW   = $clog2(COLUMNS);
	localparam int TPW   = (TAB_STOP > 1) ? $clog2(TAB_STOP) : 1;
	localparam int GW    = CLW + 5;

	localparam logic [1:0] ST_INIT  = 2'd0;
	localparam logic [1:0] ST_IDLE  = 2'd1;
	localparam logic [1:0] ST_SWEEP = 2'd2;
	localparam logic [1:0] ST_EXEC  = 2'd3;

	logic [1:0]     state_q;
	logic [CW-1:0]  cur_q;
	logic [CLW-1:0] col_q;
	logic [TPW-1:0] tp_q;
	logic [AW-1:0]  sweep_q;
	logic           copy_q;
	req_t           held_q;
	logic           held_scr_q;

	logic           wv_s1;
	logic [AW-1:0]  wa_s1;
	logic           wc_s1;

	logic           out_valid_q;
	logic [POS_W-1:0] pos_q;
	logic           wr_q;
	logic [POS_W-1:0] idx_q;
	logic [CH_W-1:0]  ch_q;
	logic           scr_q;

	logic           out_free;
	logic           past_end;
	logic           needs_sweep;
	logic           exec_fire;
	logic           apply;
	logic           sweeping;
	logic           sweep_last;
	logic           copy_now;

	req_t           op_req;
	logic           op_scr;
	logic [CW:0]    row_end;
	logic [CW:0]    next_tab;
	logic [GW-1:0]  col_tab;
	logic [CW-1:0]  n_cur;
	logic [CLW-1:0] n_col;
	logic [TPW-1:0] n_tp;
	logic           o_wr;
	logic [CW+10:0] pos_ext;
	logic [CW+10:0] idx_ext;

	logic           ram_we;
	logic [AW-1:0]  ram_waddr;
	logic [CH_W-1:0] ram_wdata;
	logic [AW:0]    rsum;
	logic [CH_W-1:0] ram_rdata;

	assign out_free    = !out_valid_q || out_ready;
	assign past_end    = (cur_q == CW'(CELLS));
	assign needs_sweep = (head.cls == CL_CLEAR) ||
		(past_end && (head.cls == CL_NL || head.cls == CL_TAB || head.cls == CL_PRINT));
	assign pop         = (state_q == ST_IDLE) && head_valid && out_free && !wv_s1;
	assign exec_fire   = (state_q == ST_EXEC) && out_free && !wv_s1;
	assign apply       = (pop && !needs_sweep) || exec_fire;
	assign sweeping    = (state_q == ST_INIT) || (state_q == ST_SWEEP);
	assign sweep_last  = (sweep_q == AW'(CELLS - 1));
	assign copy_now    = copy_q && (sweep_q < AW'(CELLS - COLUMNS));
	assign init_busy   = (state_q == ST_INIT);

	assign op_req   = (state_q == ST_EXEC) ? held_q : head;
	assign op_scr   = (state_q == ST_EXEC) ? held_scr_q : 1'b0;
	assign row_end  = (CW+1)'(cur_q) - (CW+1)'(col_q) + (CW+1)'(COLUMNS);
	assign next_tab = (CW+1)'(cur_q) + (CW+1)'(TAB_STOP) - (CW+1)'(tp_q);
	assign col_tab  = GW'(col_q) + GW'(TAB_STOP) - GW'(tp_q);

	always_comb begin
		n_cur = cur_q;
		n_col = col_q;
		n_tp  = tp_q;
		o_wr  = 1'b0;
		case (op_req.cls)
			CL_CLEAR: begin
				n_cur = '0;
				n_col = '0;
				n_tp  = '0;
			end
			CL_NL: begin
				n_cur = CW'(row_end);
				n_col = '0;
				n_tp  = '0;
			end
			CL_TAB: begin
				n_tp = '0;
				if (next_tab < row_end) begin
					n_cur = CW'(next_tab);
					n_col = CLW'(col_tab);
				end else begin
					n_cur = CW'(row_end);
					n_col = '0;
				end
			end
			CL_PRINT: begin
				o_wr  = 1'b1;
				n_cur = cur_q + CW'(1);
				if (col_q == CLW'(COLUMNS - 1)) begin
					n_col = '0;
					n_tp  = '0;
				end else begin
					n_col = col_q + CLW'(1);
					n_tp  = (tp_q == TPW'(TAB_STOP - 1)) ? '0 : tp_q + TPW'(1);
				end
			end
			default: begin
			end
		endcase
	end

	assign pos_ext = (CW+11)'(n_cur);
	assign idx_ext = (CW+11)'(cur_q);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = wa_s1;
		ram_wdata = wc_s1 ? ram_rdata : '0;
		if (wv_s1) begin
			ram_we = 1'b1;
		end else if (apply && o_wr) begin
			ram_we    = 1'b1;
			ram_waddr = cur_q[AW-1:0];
			ram_wdata = op_req.ch;
		end
	end

	assign rsum = (AW+1)'(sweep_q) + (AW+1)'(COLUMNS);

	tccs_ram #(
		.W(CH_W),
		.D(CELLS)
	) u_screen (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rsum[AW-1:0]),
		.rdata (ram_rdata)
	);

	always_ff @(posedge clk) begin
		wa_s1 <= sweep_q;
		wc_s1 <= copy_now;
		if (pop) begin
			held_q <= head;
		end
		if (apply) begin
			pos_q <= pos_ext[POS_W-1:0];
			wr_q  <= o_wr;
			idx_q <= o_wr ? idx_ext[POS_W-1:0] : '0;
			ch_q  <= o_wr ? op_req.ch : '0;
			scr_q <= op_scr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_INIT;
			cur_q       <= '0;
			col_q       <= '0;
			tp_q        <= '0;
			sweep_q     <= '0;
			copy_q      <= 1'b0;
			held_scr_q  <= 1'b0;
			wv_s1       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			wv_s1 <= sweeping;
			if (sweeping) begin
				if (sweep_last) begin
					sweep_q <= '0;
					state_q <= (state_q == ST_INIT) ? ST_IDLE : ST_EXEC;
				end else begin
					sweep_q <= sweep_q + AW'(1);
				end
			end
			if (pop && needs_sweep) begin
				state_q    <= ST_SWEEP;
				sweep_q    <= '0;
				copy_q     <= (head.cls != CL_CLEAR);
				held_scr_q <= (head.cls != CL_CLEAR);
				if (head.cls != CL_CLEAR) begin
					cur_q <= CW'(CELLS - COLUMNS);
					col_q <= '0;
					tp_q  <= '0;
				end
			end
			if (exec_fire) begin
				state_q <= ST_IDLE;
			end
			if (apply) begin
				cur_q <= n_cur;
				col_q <= n_col;
				tp_q  <= n_tp;
			end
			if (apply) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid    = out_valid_q;
	assign cursor_cell  = pos_q;
	assign cell_written = wr_q;
	assign cell_index   = idx_q;
	assign cell_char    = ch_q;
	assign scrolled     = scr_q;

`ifndef SYNTHESIS
	a_cur_range: assert property (@(posedge clk) disable iff (!arst_n)
		cur_q <= CW'(CELLS)) else $error("cursor beyond screen end");
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(col_q) < COLUMNS) else $error("column out of range");
	a_tab_phase: assert property (@(posedge clk) disable iff (!arst_n)
		int'(tp_q) < TAB_STOP) else $error("tab phase out of range");
	a_exec_free: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_EXEC |-> !out_valid_q) else $error("result slot busy after sweep");
	a_sweep_write: assert property (@(posedge clk) disable iff (!arst_n)
		sweeping |=> wv_s1) else $error("sweep write lost");
`endif

endmodule

/* dv/tccs_tb_pkg.sv */
package tccs_tb_pkg;

	localparam logic CMD_PUT   = 1'b0;
	localparam logic CMD_CLEAR = 1'b1;

endpackage

/* dv/tccs_checker.sv */
module tccs_checker #(
	parameter int COLUMNS  = 80,
	parameter int ROWS     = 25,
	parameter int TAB_STOP = 4
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	input  logic                       in_ready,
	input  logic                       cmd,
	input  logic [7:0]                 char_in,
	input  logic                       out_valid,
	input  logic                       out_ready,
	input  logic [tccs_pkg::POS_W-1:0] cursor_cell,
	input  logic                       cell_written,
	input  logic [tccs_pkg::POS_W-1:0] cell_index,
	input  logic [tccs_pkg::CH_W-1:0]  cell_char,
	input  logic                       scrolled,
	output int                         errors,
	output int                         pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import tccs_pkg::*;
	import tccs_tb_pkg::*;

	localparam int unsigned CELLS = COLUMNS * ROWS;

	typedef struct packed {
		logic [POS_W-1:0] pos;
		logic             wr;
		logic [POS_W-1:0] idx;
		logic [CH_W-1:0]  ch;
		logic             scr;
	} console_result_t;

	logic [CH_W-1:0]  screen [0:CELLS-1];
	int unsigned      cursor_model;
	console_result_t  expected_q [$];
	console_result_t  got;
	console_result_t  want;

	initial begin
		errors = 0;
		pending = 0;
		cursor_model = 0;
		for (int i = 0; i < CELLS; i++)
			screen[i] = CH_NUL;
	end

	function automatic console_result_t predict_console(input logic op,
			input logic [CH_W-1:0] ch);
		console_result_t r;
		int unsigned col;
		int unsigned row_end;
		int unsigned nxt;
		r = '0;
		if (op == CMD_CLEAR) begin
			for (int i = 0; i < CELLS; i++)
				screen[i] = CH_NUL;
			cursor_model = 0;
		end else if (ch != CH_NUL) begin
			if (cursor_model >= CELLS) begin
				for (int i = 0; i < CELLS - COLUMNS; i++)
					screen[i] = screen[i + COLUMNS];
				for (int i = CELLS - COLUMNS; i < CELLS; i++)
					screen[i] = CH_NUL;
				cursor_model = CELLS - COLUMNS;
				r.scr = 1'b1;
			end
			col = cursor_model % COLUMNS;
			row_end = cursor_model - col + COLUMNS;
			if (ch == CH_NEWLINE) begin
				cursor_model = row_end;
			end else if (ch == CH_TAB) begin
				nxt = cursor_model + TAB_STOP - (col % TAB_STOP);
				cursor_model = (nxt < row_end) ? nxt : row_end;
			end else begin
				screen[cursor_model] = ch;
				r.wr = 1'b1;
				r.idx = POS_W'(cursor_model);
				r.ch = ch;
				cursor_model = cursor_model + 1;
			end
		end
		r.pos = POS_W'(cursor_model);
		return r;
	endfunction

	function automatic void check_field(input string name, input int unsigned exp_v,
			input int unsigned act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			errors++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				expected_q.push_back(predict_console(cmd, char_in));
			if (out_valid && out_ready) begin
				got = '{cursor_cell, cell_written, cell_index, cell_char, scrolled};
				if (expected_q.size() == 0) begin
					$error("result with no request outstanding: cursor_cell %0d", cursor_cell);
					errors++;
				end else begin
					want = expected_q.pop_front();
					check_field("cursor_cell", want.pos, got.pos);
					check_field("cell_written", want.wr, got.wr);
					check_field("cell_index", want.idx, got.idx);
					check_field("cell_char", want.ch, got.ch);
					check_field("scrolled", want.scr, got.scr);
				end
			end
			pending = expected_q.size();
		end
	end

endmodule

/* dv/tb.sv */
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import tccs_pkg::*;
	import tccs_tb_pkg::*;

	localparam int COLUMNS   = 80;
	localparam int ROWS      = 25;
	localparam int TAB_STOP  = 4;
	localparam int RAND_REQS = 1050;
	localparam int LIMIT     = 8_000_000;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic             cmd = CMD_PUT;
	logic [7:0]       char_in = 8'd0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic [POS_W-1:0] cursor_cell;
	logic             cell_written;
	logic [POS_W-1:0] cell_index;
	logic [CH_W-1:0]  cell_char;
	logic             scrolled;

	int errors;
	int pending;
	int send_idle = 12;
	int recv_idle = 75;
	int cycles = 0;

	text_console_cursor_scroll #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_STOP(TAB_STOP)
	) dut (.*);

	tccs_checker #(
		.COLUMNS(COLUMNS),
		.ROWS(ROWS),
		.TAB_STOP(TAB_STOP)
	) checker_i (.*);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(negedge clk) begin
		out_ready <= ($urandom_range(99) >= recv_idle);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic send_request(input logic op, input logic [7:0] ch);
		while ($urandom_range(99) < send_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		char_in <= ch;
		do
			@(posedge clk);
		while (!in_ready);
		@(negedge clk);
	endtask

	initial begin
		int unsigned r;
		logic [7:0] ch;
		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// fill to the bottom row with newlines, then hit the past-the-end cursor
		for (int i = 0; i < ROWS; i++)
			send_request(CMD_PUT, CH_NEWLINE);
		send_request(CMD_PUT, CH_NUL);
		send_request(CMD_PUT, CH_NEWLINE);
		send_request(CMD_PUT, 8'hFF);
		send_request(CMD_PUT, 8'h01);
		send_request(CMD_PUT, CH_TAB);
		send_request(CMD_CLEAR, 8'hFF);

		// hold until the block drains
		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);

		for (int n = 0; n < RAND_REQS; n++) begin
			if (n == RAND_REQS / 3) begin
				send_idle = 75;
				recv_idle = 12;
			end else if (n == 2 * RAND_REQS / 3) begin
				send_idle = 0;
				recv_idle = 0;
			end
			r = $urandom_range(999);
			ch = 8'($urandom_range(255));
			if (r < 4) begin
				send_request(CMD_CLEAR, ch);
			end else if (r < 40) begin
				send_request(CMD_PUT, CH_NUL);
			end else if (r < 140) begin
				send_request(CMD_PUT, CH_NEWLINE);
			end else if (r < 220) begin
				send_request(CMD_PUT, CH_TAB);
			end else begin
				if (ch == CH_NUL || ch == CH_NEWLINE || ch == CH_TAB)
					ch = ch | 8'h80;
				send_request(CMD_PUT, ch);
			end
		end

		in_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (20) @(negedge clk);

		if (errors == 0 && pending == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
